// ----- src/binomial_mod_prime_lucas_unit_assert.svh -----
// Assertion macros used by the checker file of the binomial residue unit
`ifndef BINOMIAL_MOD_PRIME_LUCAS_UNIT_ASSERT_SVH
`define BINOMIAL_MOD_PRIME_LUCAS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define BML_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define BML_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bml_pkg.sv -----
// Shared types, constants and the microcode program of the binomial residue unit
package bml_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int DEFAULT_MAX_PRIME  = 256;
   localparam int DIGIT_BITS         = 8;
   localparam logic [DIGIT_BITS-1:0] PRIME_RESET = 8'd3;

   localparam int PC_BITS = 5;
   typedef logic [PC_BITS-1:0] pc_type;

   // Step addresses of the program
   localparam pc_type STEP_IDLE     = 5'd0;
   localparam pc_type STEP_CHECK    = 5'd1;
   localparam pc_type STEP_LOOP     = 5'd2;
   localparam pc_type STEP_DIV_INIT = 5'd3;
   localparam pc_type STEP_DIV      = 5'd4;
   localparam pc_type STEP_COMPARE  = 5'd5;
   localparam pc_type STEP_CLR_INIT = 5'd6;
   localparam pc_type STEP_CLR      = 5'd7;
   localparam pc_type STEP_ROW_INIT = 5'd8;
   localparam pc_type STEP_ROW      = 5'd9;
   localparam pc_type STEP_READ_LO  = 5'd10;
   localparam pc_type STEP_INNER    = 5'd11;
   localparam pc_type STEP_ROW_NEXT = 5'd12;
   localparam pc_type STEP_READ_RD  = 5'd13;
   localparam pc_type STEP_MUL_INIT = 5'd14;
   localparam pc_type STEP_MUL      = 5'd15;
   localparam pc_type STEP_MUL_DONE = 5'd16;
   localparam pc_type STEP_ZERO     = 5'd17;
   localparam pc_type STEP_EMIT     = 5'd18;
   localparam pc_type STEP_RETURN   = 5'd19;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_CLR_INIT,
      OP_CLR,
      OP_ROW_INIT,
      OP_ROW_TOP,
      OP_READ_LO,
      OP_INNER,
      OP_ROW_NEXT,
      OP_READ_RD,
      OP_MUL_INIT,
      OP_MUL_STEP,
      OP_PROD_LOAD,
      OP_PROD_ZERO,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_P_BAD,
      COND_R_ZERO,
      COND_CNT_MORE,
      COND_RD_GT_ND,
      COND_J_NE_RD,
      COND_RD_ZERO,
      COND_J_NE_ONE,
      COND_I_NE_ND,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic p_bad;
      logic r_zero;
      logic cnt_more;
      logic rd_gt_nd;
      logic j_ne_rd;
      logic rd_zero;
      logic j_ne_one;
      logic i_ne_nd;
      logic out_busy;
   } status_type;

   // Control store: one word per step, jump to target when cond holds
   function automatic ctrl_type ucode(input pc_type pc);
      ctrl_type w;
      case (pc)
         STEP_IDLE:     w = '{OP_LOAD,      COND_NO_REQ,   STEP_IDLE};
         STEP_CHECK:    w = '{OP_NOP,       COND_P_BAD,    STEP_ZERO};
         STEP_LOOP:     w = '{OP_NOP,       COND_R_ZERO,   STEP_EMIT};
         STEP_DIV_INIT: w = '{OP_DIV_INIT,  COND_NEVER,    STEP_IDLE};
         STEP_DIV:      w = '{OP_DIV_STEP,  COND_CNT_MORE, STEP_DIV};
         STEP_COMPARE:  w = '{OP_NOP,       COND_RD_GT_ND, STEP_ZERO};
         STEP_CLR_INIT: w = '{OP_CLR_INIT,  COND_NEVER,    STEP_IDLE};
         STEP_CLR:      w = '{OP_CLR,       COND_J_NE_RD,  STEP_CLR};
         STEP_ROW_INIT: w = '{OP_ROW_INIT,  COND_RD_ZERO,  STEP_READ_RD};
         STEP_ROW:      w = '{OP_ROW_TOP,   COND_NEVER,    STEP_IDLE};
         STEP_READ_LO:  w = '{OP_READ_LO,   COND_NEVER,    STEP_IDLE};
         STEP_INNER:    w = '{OP_INNER,     COND_J_NE_ONE, STEP_INNER};
         STEP_ROW_NEXT: w = '{OP_ROW_NEXT,  COND_I_NE_ND,  STEP_ROW};
         STEP_READ_RD:  w = '{OP_READ_RD,   COND_NEVER,    STEP_IDLE};
         STEP_MUL_INIT: w = '{OP_MUL_INIT,  COND_NEVER,    STEP_IDLE};
         STEP_MUL:      w = '{OP_MUL_STEP,  COND_CNT_MORE, STEP_MUL};
         STEP_MUL_DONE: w = '{OP_PROD_LOAD, COND_ALWAYS,   STEP_LOOP};
         STEP_ZERO:     w = '{OP_PROD_ZERO, COND_NEVER,    STEP_IDLE};
         STEP_EMIT:     w = '{OP_EMIT,      COND_OUT_BUSY, STEP_EMIT};
         STEP_RETURN:   w = '{OP_NOP,       COND_ALWAYS,   STEP_IDLE};
         default:       w = '{OP_NOP,       COND_ALWAYS,   STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- src/bml_sequencer.sv -----
// Step counter, control store lookup and conditional jump logic
module bml_sequencer
   import bml_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   pc_type pc_ff;
   pc_type pc_in;
   logic   take;

   assign ctrl = ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = status.no_req;
         COND_P_BAD:    take = status.p_bad;
         COND_R_ZERO:   take = status.r_zero;
         COND_CNT_MORE: take = status.cnt_more;
         COND_RD_GT_ND: take = status.rd_gt_nd;
         COND_J_NE_RD:  take = status.j_ne_rd;
         COND_RD_ZERO:  take = status.rd_zero;
         COND_J_NE_ONE: take = status.j_ne_one;
         COND_I_NE_ND:  take = status.i_ne_nd;
         COND_OUT_BUSY: take = status.out_busy;
         default:       take = 1'b0;
      endcase
      pc_in = take ? ctrl.target : pc_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- src/bml_datapath.sv -----
// Digit divider, Pascal row store, modular multiplier and output register
module bml_datapath
   import bml_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
   parameter int MAX_PRIME  = DEFAULT_MAX_PRIME
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_type              ctrl,
   output status_type            status,
   input  logic                  req_valid,
   input  logic [VALUE_BITS-1:0] req_top_count,
   input  logic [VALUE_BITS-1:0] req_choose_count,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [DIGIT_BITS-1:0] rsp_residue,
   input  logic                  csr_write,
   input  logic [DIGIT_BITS-1:0] csr_prime_modulus
);

   localparam int ADDR_BITS = $clog2(MAX_PRIME);
   localparam int CNT_BITS  = $clog2(VALUE_BITS + 1);
   localparam logic [DIGIT_BITS:0] MAX_P_WIDE = (DIGIT_BITS + 1)'(MAX_PRIME);

   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [DIGIT_BITS:0]   wide_type;

   // Bring x below m, given x < 2m
   function automatic digit_type reduce(input wide_type x, input wide_type m);
      wide_type d;
      d = x - m;
      return (x >= m) ? d[DIGIT_BITS-1:0] : x[DIGIT_BITS-1:0];
   endfunction

   digit_type prime_ff;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] r_ff, r_in;
   digit_type nd_ff, nd_in;
   digit_type rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   digit_type i_ff, i_in;
   digit_type j_ff, j_in;
   digit_type hold_ff, hold_in;
   digit_type mcand_ff, mcand_in;
   digit_type mplier_ff, mplier_in;
   digit_type acc_ff, acc_in;
   digit_type prod_ff, prod_in;
   logic      rsp_valid_ff, rsp_valid_in;
   digit_type rsp_residue_ff;
   digit_type rdata_ff;

   digit_type row_mem [MAX_PRIME];

   logic                 mem_we;
   logic                 mem_re;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [ADDR_BITS-1:0] mem_raddr;
   digit_type            mem_wdata;

   wide_type  p_wide;
   wide_type  n_shift;
   wide_type  r_shift;
   digit_type top;
   digit_type j_minus1;
   digit_type j_minus2;
   digit_type sum_mod;
   digit_type dbl_mod;
   digit_type addend;
   digit_type mul_next;
   logic      out_busy;
   logic      emit;

   assign p_wide   = {1'b0, prime_ff};
   assign n_shift  = {nd_ff, n_ff[VALUE_BITS-1]};
   assign r_shift  = {rd_ff, r_ff[VALUE_BITS-1]};
   assign top      = (i_ff < rd_ff) ? i_ff : rd_ff;
   assign j_minus1 = j_ff - 1'b1;
   assign j_minus2 = j_ff - 2'd2;
   assign sum_mod  = reduce({1'b0, hold_ff} + {1'b0, rdata_ff}, p_wide);
   assign dbl_mod  = reduce({acc_ff, 1'b0}, p_wide);
   assign addend   = mplier_ff[DIGIT_BITS-1] ? mcand_ff : '0;
   assign mul_next = reduce({1'b0, dbl_mod} + {1'b0, addend}, p_wide);
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

   always_comb begin
      status.no_req   = !req_valid;
      status.p_bad    = (prime_ff < DIGIT_BITS'(2)) || (p_wide > MAX_P_WIDE);
      status.r_zero   = (r_ff == '0);
      status.cnt_more = (cnt_ff != CNT_BITS'(1));
      status.rd_gt_nd = (rd_ff > nd_ff);
      status.j_ne_rd  = (j_ff != rd_ff);
      status.rd_zero  = (rd_ff == '0);
      status.j_ne_one = (j_ff != DIGIT_BITS'(1));
      status.i_ne_nd  = (i_ff != nd_ff);
      status.out_busy = out_busy;
   end

   always_comb begin
      n_in      = n_ff;
      r_in      = r_ff;
      nd_in     = nd_ff;
      rd_in     = rd_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      hold_in   = hold_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = j_ff[ADDR_BITS-1:0];
      mem_wdata = sum_mod;
      mem_raddr = rd_ff[ADDR_BITS-1:0];
      case (ctrl.op)
         OP_LOAD: begin
            if (req_valid) begin
               n_in    = req_top_count;
               r_in    = req_choose_count;
               prod_in = DIGIT_BITS'(1);
            end
         end
         OP_DIV_INIT: begin
            nd_in  = '0;
            rd_in  = '0;
            cnt_in = CNT_BITS'(VALUE_BITS);
         end
         OP_DIV_STEP: begin
            // one quotient bit per step for both operands
            n_in   = {n_ff[VALUE_BITS-2:0], (n_shift >= p_wide)};
            r_in   = {r_ff[VALUE_BITS-2:0], (r_shift >= p_wide)};
            nd_in  = reduce(n_shift, p_wide);
            rd_in  = reduce(r_shift, p_wide);
            cnt_in = cnt_ff - 1'b1;
         end
         OP_CLR_INIT: begin
            j_in = '0;
         end
         OP_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = (j_ff == '0) ? DIGIT_BITS'(1) : '0;
            j_in      = j_ff + 1'b1;
         end
         OP_ROW_INIT: begin
            i_in = DIGIT_BITS'(1);
         end
         OP_ROW_TOP: begin
            j_in      = top;
            mem_re    = 1'b1;
            mem_raddr = top[ADDR_BITS-1:0];
         end
         OP_READ_LO: begin
            mem_re    = 1'b1;
            mem_raddr = j_minus1[ADDR_BITS-1:0];
            hold_in   = rdata_ff;
         end
         OP_INNER: begin
            // write entry j, fetch entry j-2 for the next step down
            mem_we    = 1'b1;
            mem_re    = 1'b1;
            mem_raddr = j_minus2[ADDR_BITS-1:0];
            hold_in   = rdata_ff;
            j_in      = j_minus1;
         end
         OP_ROW_NEXT: begin
            i_in = i_ff + 1'b1;
         end
         OP_READ_RD: begin
            mem_re = 1'b1;
         end
         OP_MUL_INIT: begin
            mcand_in  = rdata_ff;
            mplier_in = prod_ff;
            acc_in    = '0;
            cnt_in    = CNT_BITS'(DIGIT_BITS);
         end
         OP_MUL_STEP: begin
            acc_in    = mul_next;
            mplier_in = {mplier_ff[DIGIT_BITS-2:0], 1'b0};
            cnt_in    = cnt_ff - 1'b1;
         end
         OP_PROD_LOAD: begin
            prod_in = acc_ff;
         end
         OP_PROD_ZERO: begin
            prod_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff     <= PRIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            prime_ff <= csr_prime_modulus;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      r_ff      <= r_in;
      nd_ff     <= nd_in;
      rd_ff     <= rd_in;
      cnt_ff    <= cnt_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      hold_ff   <= hold_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      if (emit) begin
         rsp_residue_ff <= prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= row_mem[mem_raddr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

endmodule

// ----- src/binomial_mod_prime_lucas_unit.sv -----
// Top level: n choose r modulo a configured prime, one item at a time
// Per base-p digit pair: divide both operands by the modulus, compare the digits, clear the
//   row store, build Pascal rows 1..nd (none when rd is zero), read entry rd and multiply it in;
//   a digit with rd above nd ends the item with result 0, and a bad modulus gives 0.
// The next item is taken once the last result is registered, even while that result is stalled.
// Reset clears the step counter and rsp_valid and sets the modulus to 3, not the row store.
module binomial_mod_prime_lucas_unit
   import bml_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
   parameter int MAX_PRIME  = DEFAULT_MAX_PRIME
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_top_count,
   input  logic [VALUE_BITS-1:0] req_choose_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DIGIT_BITS-1:0] rsp_residue,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DIGIT_BITS-1:0] csr_prime_modulus
);

   ctrl_type   ctrl;
   status_type status;

   assign req_stall = (ctrl.op != OP_LOAD);
   assign csr_ready = 1'b1;

   bml_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   bml_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_PRIME  (MAX_PRIME)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_valid         (req_valid),
      .req_top_count     (req_top_count),
      .req_choose_count  (req_choose_count),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_residue       (rsp_residue),
      .csr_write         (csr_valid && csr_ready),
      .csr_prime_modulus (csr_prime_modulus)
   );

endmodule

// ----- src/bml_checker.sv -----
// Port-level checker for the binomial residue unit and its bind
`include "binomial_mod_prime_lucas_unit_assert.svh"

module bml_checker
   import bml_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DIGIT_BITS-1:0] rsp_residue
);

   // Out of reset: no result shown, ready for a request
   `BML_ASSERT_NOW(a_reset_state, $fell(reset), !rsp_valid && !req_stall, "bad state after reset")

   // One item at a time: a taken request blocks the next one
   `BML_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "took back-to-back beat")

   // A new result only appears while the sequencer is away from its idle step
   `BML_ASSERT_NOW(a_rise_while_busy, $rose(rsp_valid), req_stall, "result rose while idle")

   `BML_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_residue),
      "stalled result beat changed")

endmodule

bind binomial_mod_prime_lucas_unit bml_checker u_bml_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_residue (rsp_residue)
);

// ----- dv/binomial_mod_prime_lucas_unit_tb.sv -----
// Self-checking testbench of the Lucas binomial residue unit, with random flow control
`timescale 1ns / 1ps

module binomial_mod_prime_lucas_unit_tb
   import bml_pkg::*;
();

   localparam int VALUE_BITS    = DEFAULT_VALUE_BITS;
   localparam int SETTLE_CYCLES = 64;
   localparam longint CYCLE_LIMIT = 40_000_000;

   typedef struct {
      logic [VALUE_BITS-1:0] top_count;
      logic [VALUE_BITS-1:0] choose_count;
      logic [DIGIT_BITS-1:0] modulus;
      logic [DIGIT_BITS-1:0] residue;
   } residue_entry_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_top_count;
   logic [VALUE_BITS-1:0] req_choose_count;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DIGIT_BITS-1:0] rsp_residue;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [DIGIT_BITS-1:0] csr_prime_modulus;

   residue_entry_type     pending_residues[$];
   residue_entry_type     arrived;
   logic [DIGIT_BITS-1:0] modulus;
   int                    error_count = 0;
   int                    burst_left = 0;
   int                    hold_left = 0;
   longint                cycle_count = 0;

   binomial_mod_prime_lucas_unit #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_PRIME (DEFAULT_MAX_PRIME)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_top_count    (req_top_count),
      .req_choose_count (req_choose_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_residue      (rsp_residue),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_prime_modulus(csr_prime_modulus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Entry rd of Pascal row nd, built in place with every sum reduced mod p
   function automatic int unsigned pascal_entry(int unsigned nd, int unsigned rd,
                                                int unsigned p);
      logic [DIGIT_BITS-1:0] row [0:DEFAULT_MAX_PRIME-1];
      int unsigned top;
      for (int k = 0; k < DEFAULT_MAX_PRIME; k++) row[k] = '0;
      row[0] = DIGIT_BITS'(1);
      for (int unsigned i = 1; i <= nd; i++) begin
         top = (i < rd) ? i : rd;
         for (int unsigned j = top; j > 0; j--)
            row[j] = DIGIT_BITS'((int'(row[j]) + int'(row[j-1])) % p);
      end
      return row[rd];
   endfunction

   function automatic logic [DIGIT_BITS-1:0] lucas_residue(logic [VALUE_BITS-1:0] n,
                                                           logic [VALUE_BITS-1:0] r,
                                                           logic [DIGIT_BITS-1:0] p);
      logic [VALUE_BITS-1:0] rest_n, rest_r;
      int unsigned nd, rd, db, prod;
      if (p < 2) return '0;
      prod   = 1;
      rest_n = n;
      rest_r = r;
      while (rest_r != 0) begin
         nd     = rest_n % p;
         rd     = rest_r % p;
         db     = (rd > nd) ? 0 : pascal_entry(nd, rd, p);
         prod   = (prod * db) % p;
         rest_n = rest_n / p;
         rest_r = rest_r / p;
      end
      return prod[DIGIT_BITS-1:0];
   endfunction

   // Random r whose base-p digits never exceed those of n, so no digit zeroes the product
   function automatic logic [VALUE_BITS-1:0] covered_choose(logic [VALUE_BITS-1:0] n,
                                                            logic [DIGIT_BITS-1:0] p);
      logic [63:0] place, r;
      logic [VALUE_BITS-1:0] rest;
      int unsigned nd;
      place = 1;
      r     = 0;
      rest  = n;
      while (rest != 0) begin
         nd    = rest % p;
         r     = r + place * $urandom_range(0, nd);
         rest  = rest / p;
         place = place * p;
      end
      return r[VALUE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH: %s", what);
      error_count++;
   endtask

   task automatic send_pair(input logic [VALUE_BITS-1:0] n, input logic [VALUE_BITS-1:0] r);
      residue_entry_type entry;
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 7))
            0:       gap = $urandom_range(100, 1500);
            1, 2:    gap = $urandom_range(1, 20);
            default: gap = 0;
         endcase
         burst_left = $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_top_count    <= n;
      req_choose_count <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      entry.top_count    = n;
      entry.choose_count = r;
      entry.modulus      = modulus;
      entry.residue      = lucas_residue(n, r, modulus);
      pending_residues   = {pending_residues, entry};
      burst_left--;
   endtask

   // Drop valid and wait until the unit has returned everything and gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_residues.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [DIGIT_BITS-1:0] p);
      settle();
      csr_valid         <= 1'b1;
      csr_prime_modulus <= p;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      modulus = p;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_pairs(input int count, input bit single_digit);
      logic [VALUE_BITS-1:0] n, r;
      for (int k = 0; k < count; k++) begin
         n = $urandom() >> $urandom_range(0, 24);
         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom();
               r = $urandom() >> $urandom_range(0, 32);
            end
            2, 3, 4, 5: r = (modulus < 2) ? $urandom() : covered_choose(n, modulus);
            6:          r = n;
            7: begin
               n = ($urandom_range(0, 1) == 0) ? '0 : '1;
               r = ($urandom_range(0, 1) == 0) ? '1 : VALUE_BITS'($urandom_range(0, 3));
            end
            8:          r = '0;
            default:    r = n + VALUE_BITS'($urandom_range(1, 40));
         endcase
         if (single_digit) r = r % modulus;
         send_pair(n, r);
      end
   endtask

   task automatic test_reset_modulus();
      send_pair('0, '0);
      send_pair('1, '1);
      send_pair('1, '0);
      send_pair('0, '1);
      send_pair(32'd10, 32'd4);
      send_pair(32'd5, 32'd2);
      write_modulus(8'd2);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair('1, 32'h1234_5678);
   endtask

   task automatic test_degenerate_moduli();
      write_modulus(8'd0);
      send_pair(32'd10, 32'd3);
      send_pair('0, '0);
      write_modulus(8'd1);
      send_pair('1, 32'd1);
      send_pair('0, '0);
   endtask

   task automatic test_large_moduli();
      write_modulus(8'd251);
      send_pair(32'd250, 32'd125);
      send_pair(32'd250, 32'd250);
      send_pair(32'd200, 32'd201);
      write_modulus(8'd255);
      send_pair(32'd254, 32'd127);
      send_pair('1, '1);
   endtask

   task automatic test_composite_modulus();
      write_modulus(8'd4);
      send_pair(32'd6, 32'd2);
      send_pair(32'd15, 32'd5);
      send_pair('1, 32'hAAAA_AAAA);
   endtask

   // Hold the result side off long enough that the unit backs up into its input
   task automatic test_output_hold_off();
      write_modulus(8'd3);
      hold_left = 6000;
      for (int k = 0; k < 12; k++)
         send_pair($urandom(), VALUE_BITS'($urandom_range(0, 255)));
      settle();
   endtask

   task automatic test_random_moduli();
      logic [DIGIT_BITS-1:0] small_primes [6] = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13};
      foreach (small_primes[k]) begin
         write_modulus(small_primes[k]);
         send_random_pairs(175, 1'b0);
      end
      write_modulus(8'd0);
      send_random_pairs(10, 1'b0);
      write_modulus(8'd1);
      send_random_pairs(10, 1'b0);
      write_modulus(8'd4);
      send_random_pairs(30, 1'b0);
      write_modulus(8'd9);
      send_random_pairs(20, 1'b0);
      // large moduli make rows long: keep r to a single digit
      write_modulus(8'd251);
      send_random_pairs(20, 1'b1);
      write_modulus(8'd255);
      send_random_pairs(10, 1'b1);
   endtask

   // Result receiver: stall pattern changes mode every so often
   initial begin
      int stall_mode, mode_left;
      rsp_stall  = 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 2000);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= mode_left[2];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_residues.size() == 0) begin
            report_mismatch($sformatf("residue %0d with no item outstanding", rsp_residue));
         end else begin
            arrived = pending_residues.pop_front();
            if (rsp_residue !== arrived.residue)
               report_mismatch($sformatf("n=%h r=%h p=%0d: residue %0d, want %0d",
                                         arrived.top_count, arrived.choose_count,
                                         arrived.modulus, rsp_residue, arrived.residue));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("binomial_mod_prime_lucas_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_top_count     = '0;
      req_choose_count  = '0;
      csr_valid         = 1'b0;
      csr_prime_modulus = '0;
      modulus           = PRIME_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_modulus();
      test_degenerate_moduli();
      test_large_moduli();
      test_composite_modulus();
      test_output_hold_off();
      test_random_moduli();
      settle();
      if (error_count == 0)
         $display("binomial_mod_prime_lucas_unit_tb: done, clean");
      else
         $display("binomial_mod_prime_lucas_unit_tb: done, errors");
      $finish;
   end

endmodule

// ----- binomial_mod_prime_lucas_unit.f -----
+incdir+src
src/bml_pkg.sv
src/bml_sequencer.sv
src/bml_datapath.sv
src/binomial_mod_prime_lucas_unit.sv
src/bml_checker.sv
dv/binomial_mod_prime_lucas_unit_tb.sv
